@@ rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] rank;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    status_t     status;
    entry_t      entry;
    logic [3:0]  occupancy;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/spq_mem.sv @@
// Entry storage: one write port, one read port with registered read data.
`default_nettype none

module spq_mem
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_entry,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_entry
);

  entry_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      slots[wr_addr] <= wr_entry;
    end
    // read data holds while no read is issued
    if (ctl.rd_en) begin
      rd_entry <= slots[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// Sequencer: walks the entry memory one slot per step, shared rank compare.
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_action,
  input  wire entry_t        in_entry,
  output mem_ctl_t           mem_ctl,
  output logic [AW-1:0]      wr_addr,
  output entry_t             wr_entry,
  output logic [AW-1:0]      rd_addr,
  input  wire entry_t        rd_entry,
  input  wire logic          out_free,
  output logic               res_valid,
  output res_t               res
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_CMP = 7'b0000010,
    S_INS_PUT = 7'b0000100,
    S_REM_CAP = 7'b0001000,
    S_REM_MOV = 7'b0010000,
    S_LST_OUT = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx, idx_next;
  entry_t        key, key_next;
  entry_t        hold, hold_next;
  res_t          pend, pend_next;

  function automatic logic [3:0] occ(input logic [CW-1:0] f);
    logic [CW+3:0] e;
    e = {4'b0, f};
    return e[3:0];
  endfunction

  function automatic res_t mk_res(input status_t st, input entry_t en,
                                  input logic [CW-1:0] f, input logic lst);
    res_t r;
    r.status    = st;
    r.entry     = en;
    r.occupancy = occ(f);
    r.last      = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
    idx  <= idx_next;
    key  <= key_next;
    hold <= hold_next;
    pend <= pend_next;
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    key_next   = key;
    hold_next  = hold;
    pend_next  = pend;
    mem_ctl    = '0;
    wr_addr    = idx[AW-1:0];
    wr_entry   = key;
    rd_addr    = idx[AW-1:0];
    res_valid  = 1'b0;
    res        = pend;
    in_ready   = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next = in_entry;
          case (in_action)
            ACT_INSERT: begin
              if (fill == FULL_CNT) begin
                pend_next  = mk_res(ST_FULL, '0, fill, 1'b1);
                state_next = S_RESP;
              end else if (fill == '0) begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = '0;
                wr_entry      = in_entry;
                fill_next     = CW'(1);
                pend_next     = mk_res(ST_OK, '0, CW'(1), 1'b1);
                state_next    = S_RESP;
              end else begin
                // walk down from the top, shifting larger ranks up
                idx_next      = fill;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = AW'(fill - CW'(1));
                state_next    = S_INS_CMP;
              end
            end
            ACT_REMOVE: begin
              if (fill == '0) begin
                pend_next  = mk_res(ST_EMPTY, '0, fill, 1'b1);
                state_next = S_RESP;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = '0;
                idx_next      = CW'(1);
                state_next    = S_REM_CAP;
              end
            end
            ACT_LIST: begin
              if (fill == '0) begin
                pend_next  = mk_res(ST_EMPTY, '0, fill, 1'b1);
                state_next = S_RESP;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = '0;
                idx_next      = '0;
                state_next    = S_LST_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_CMP: begin
        // rd_entry holds slot idx-1
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx[AW-1:0];
        if ($signed(rd_entry.rank) > $signed(key.rank)) begin
          wr_entry = rd_entry;
          idx_next = CW'(idx - CW'(1));
          if (idx == CW'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(idx - CW'(2));
          end
        end else begin
          wr_entry   = key;
          fill_next  = CW'(fill + CW'(1));
          pend_next  = mk_res(ST_OK, '0, CW'(fill + CW'(1)), 1'b1);
          state_next = S_RESP;
        end
      end

      S_INS_PUT: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx[AW-1:0];
        wr_entry      = key;
        fill_next     = CW'(fill + CW'(1));
        pend_next     = mk_res(ST_OK, '0, CW'(fill + CW'(1)), 1'b1);
        state_next    = S_RESP;
      end

      S_REM_CAP: begin
        hold_next = rd_entry;
        if (idx == fill) begin
          fill_next  = CW'(fill - CW'(1));
          pend_next  = mk_res(ST_OK, rd_entry, CW'(fill - CW'(1)), 1'b1);
          state_next = S_RESP;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx[AW-1:0];
          state_next    = S_REM_MOV;
        end
      end

      S_REM_MOV: begin
        // rd_entry holds slot idx, moves down one
        mem_ctl.wr_en = 1'b1;
        wr_addr       = AW'(idx - CW'(1));
        wr_entry      = rd_entry;
        idx_next      = CW'(idx + CW'(1));
        if (CW'(idx + CW'(1)) == fill) begin
          fill_next  = CW'(fill - CW'(1));
          pend_next  = mk_res(ST_OK, hold, CW'(fill - CW'(1)), 1'b1);
          state_next = S_RESP;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = AW'(idx + CW'(1));
        end
      end

      S_LST_OUT: begin
        if (out_free) begin
          res_valid = 1'b1;
          res       = mk_res(ST_OK, rd_entry, fill, CW'(idx + CW'(1)) == fill);
          if (CW'(idx + CW'(1)) == fill) begin
            state_next = S_IDLE;
          end else begin
            idx_next      = CW'(idx + CW'(1));
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(idx + CW'(1));
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue, top level with output register.
// Holds up to DEPTH (value, rank) entries in ascending rank order in a small
// single-read-port memory; equal ranks keep arrival order. One transfer is
// taken at a time and s_axis_tready stays low until its results are handed
// to the output register. An insert shifts each stored entry of larger rank
// up one slot, walking down from the top, then writes the new entry; a
// remove takes the head and moves each entry left behind down one slot; a
// list hands out one result per cycle while m_axis_tready is high; errors
// and empty cases give one status result, an unused action code none.
// A result still waiting in the output register holds the sequencer. The
// pace is set by the one read port of the entry memory, whose read data
// is registered, and by the sequencer stepping one slot at a time.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // item_value[31:0], item_rank[47:32]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // out_value[31:0], out_rank[47:32],
                                          // occupancy[51:48], zero[55:52]
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  output logic             m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  entry_t        wr_entry;
  entry_t        rd_entry;
  entry_t        in_entry;
  logic          out_free;
  logic          res_valid;
  res_t          res;
  res_t          res_q;

  assign in_entry.value = s_axis_tdata[31:0];
  assign in_entry.rank  = s_axis_tdata[47:32];
  assign out_free       = !m_axis_tvalid || m_axis_tready;

  spq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_entry  (in_entry),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {4'b0, res_q.occupancy, res_q.entry.rank, res_q.entry.value};
  assign m_axis_tuser = res_q.status;
  assign m_axis_tlast = res_q.last;

endmodule

`default_nettype wire

@@ tb/tb_sorted_priority_queue.sv @@
// Testbench for the sorted priority queue: random and directed stream traffic checked against a shadow queue.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 407;
  localparam int GAP_MAX = 18;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] value;
    logic [15:0] rank;
    int unsigned gap;
  } queue_op_t;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [15:0] rank;
    logic [3:0]  occ;
    logic        last;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // item_value[31:0], item_rank[47:32]
  logic [1:0]  s_axis_tuser = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // out_value[31:0], out_rank[47:32], occupancy[51:48]
  logic [1:0]  m_axis_tuser;       // status[1:0]
  logic        m_axis_tlast;

  sorted_priority_queue #(.DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  queue_op_t     op_backlog[$];
  queue_result_t due_results[$];
  queue_op_t     cur_op;
  bit            have_op = 1'b0;
  bit            in_xfer = 1'b0;
  bit            out_xfer = 1'b0;
  int unsigned   in_gap = 0;
  int unsigned   out_wait = 0;
  int unsigned   hold_left = 0;
  int unsigned   rx_seg_left = 0;
  bit            rx_calm = 1'b0;
  int unsigned   n_results = 0;
  int unsigned   n_fail = 0;
  int unsigned   idle_cycles = 0;

  // shadow copy of the sorted store
  logic [31:0] shadow_value[DEPTH];
  logic [15:0] shadow_rank[DEPTH];
  int          shadow_fill = 0;

  function automatic void add_due(status_t st, logic [31:0] v, logic [15:0] r, logic lst);
    queue_result_t res;
    res.status = st;
    res.value  = v;
    res.rank   = r;
    res.occ    = shadow_fill[3:0];
    res.last   = lst;
    due_results.push_back(res);
  endfunction

  function automatic void update_shadow_queue(queue_op_t op);
    int pos;
    logic [31:0] v;
    logic [15:0] r;
    case (op.act)
      ACT_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          add_due(ST_FULL, '0, '0, 1'b1);
        end else begin
          // new entry goes behind every entry of equal or smaller rank
          pos = 0;
          while (pos < shadow_fill && $signed(shadow_rank[pos]) <= $signed(op.rank)) pos++;
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_rank[i]  = shadow_rank[i-1];
          end
          shadow_value[pos] = op.value;
          shadow_rank[pos]  = op.rank;
          shadow_fill++;
          add_due(ST_OK, '0, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (shadow_fill == 0) begin
          add_due(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          v = shadow_value[0];
          r = shadow_rank[0];
          for (int i = 1; i < shadow_fill; i++) begin
            shadow_value[i-1] = shadow_value[i];
            shadow_rank[i-1]  = shadow_rank[i];
          end
          shadow_fill--;
          add_due(ST_OK, v, r, 1'b1);
        end
      end
      ACT_LIST: begin
        if (shadow_fill == 0) begin
          add_due(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            add_due(ST_OK, shadow_value[i], shadow_rank[i], i + 1 == shadow_fill);
        end
      end
      default: ;  // unused code: no result
    endcase
  endfunction

  function automatic void check_field(string field, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
      n_fail++;
    end
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // transfers and checks, sampled at the rising edge
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (!rst) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        update_shadow_queue(cur_op);
        in_xfer = 1'b1;
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_xfer = 1'b1;
        idle_cycles = 0;
        n_results++;
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: tdata 0x%0h tuser %0d",
                 m_axis_tdata, m_axis_tuser);
          n_fail++;
        end else begin
          exp_res = due_results.pop_front();
          check_field("status", exp_res.status, m_axis_tuser);
          check_field("out_value", exp_res.value, m_axis_tdata[31:0]);
          check_field("out_rank", exp_res.rank, m_axis_tdata[47:32]);
          check_field("occupancy", exp_res.occ, m_axis_tdata[51:48]);
          check_field("last", exp_res.last, m_axis_tlast);
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst) begin
      if (in_xfer) begin
        in_xfer = 1'b0;
        have_op = 1'b0;
      end
      if (!have_op) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (op_backlog.size() > 0) begin
          cur_op  = op_backlog.pop_front();
          have_op = 1'b1;
          in_gap  = cur_op.gap;  // gap taken after this transfer
        end
      end
      s_axis_tvalid <= have_op;
      s_axis_tdata  <= have_op ? {cur_op.rank, cur_op.value} : '0;
      s_axis_tuser  <= have_op ? cur_op.act : '0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (out_xfer) begin
        out_xfer = 1'b0;
        if (rx_seg_left == 0) begin
          rx_calm     = ($urandom_range(0, 3) == 0);
          rx_seg_left = $urandom_range(10, 40);
        end
        rx_seg_left--;
        out_wait = draw_gap(rx_calm);
        // long back-pressure so the block fills and stalls its input
        if (n_results == 80 || n_results == 500) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_op(logic [1:0] act, logic [31:0] value, logic [15:0] rank,
                        int unsigned gap);
    queue_op_t op;
    op.act   = act;
    op.value = value;
    op.rank  = rank;
    op.gap   = gap;
    op_backlog.push_back(op);
  endtask

  initial begin
    int unsigned seg_left;
    int unsigned mode;
    bit          calm;
    int unsigned pick;
    logic [1:0]  act;
    logic [15:0] rank;

    // directed: empty cases, extremes, ties, full, list of a full queue
    add_op(ACT_LIST,   32'h0,        16'h0,    0);
    add_op(ACT_REMOVE, 32'h0,        16'h0,    3);
    add_op(ACT_INSERT, 32'h7FFFFFFF, 16'h7FFF, 0);
    add_op(ACT_INSERT, 32'h80000000, 16'h8000, 0);
    add_op(ACT_INSERT, 32'h00000000, 16'h0000, 5);
    add_op(ACT_INSERT, 32'h00000001, 16'h0000, 0);
    add_op(ACT_INSERT, 32'hFFFFFFFF, 16'hFFFF, 0);
    add_op(ACT_INSERT, 32'h12345678, 16'h7FFF, 1);
    add_op(ACT_INSERT, 32'hA5A5A5A5, 16'h8000, 0);
    add_op(ACT_INSERT, 32'h5A5A5A5A, 16'h0001, 0);
    add_op(ACT_INSERT, 32'hDEADBEEF, 16'h0002, 0);  // full
    add_op(ACT_LIST,   32'h0,        16'h0,    2);
    add_op(ACT_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 0);
    for (int i = 0; i < DEPTH; i++) add_op(ACT_REMOVE, 32'h0, 16'h0, i % 3);
    add_op(ACT_REMOVE, 32'h0,        16'h0,    0);
    add_op(ACT_LIST,   32'h0,        16'h0,    0);

    // random: runs that fill, drain or mix, with ties and extreme ranks
    seg_left = 0;
    mode = 0;
    calm = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        mode     = $urandom_range(0, 2);
        calm     = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      case (mode)
        0:       act = pick < 70 ? ACT_INSERT : pick < 85 ? ACT_REMOVE : ACT_LIST;
        1:       act = pick < 70 ? ACT_REMOVE : pick < 85 ? ACT_INSERT : ACT_LIST;
        default: act = pick < 40 ? ACT_INSERT : pick < 75 ? ACT_REMOVE : ACT_LIST;
      endcase
      if ($urandom_range(0, 59) == 0) act = ACT_UNUSED;
      case ($urandom_range(0, 3))
        0, 1:    rank = 16'($signed($urandom_range(0, 6)) - 3);
        2: begin
          case ($urandom_range(0, 3))
            0:       rank = 16'h8000;
            1:       rank = 16'h7FFF;
            2:       rank = 16'h8001;
            default: rank = 16'h7FFE;
          endcase
        end
        default: rank = 16'($urandom);
      endcase
      add_op(act, $urandom, rank, draw_gap(calm));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (op_backlog.size() > 0 || have_op || due_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
